/* design/hpev_pkg.sv */
// Shared types and constants for the host and port endpoint validator.
package hpev_pkg;

	localparam logic [8:0] MAX_TEXT        = 9'd260;
	localparam logic [9:0] MAX_DOMAIN      = 10'd253;
	localparam logic [6:0] MAX_LABEL       = 7'd63;
	localparam logic [2:0] MAX_PORT_DIGITS = 3'd5;
	localparam logic [16:0] MAX_PORT       = 17'd65535;
	localparam logic [9:0] MAX_OCTET       = 10'd255;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_TOO_LONG    = 4'd1,
		ST_WHITESPACE  = 4'd2,
		ST_BRACKETED   = 4'd3,
		ST_BAD_COLON   = 4'd4,
		ST_PORT_EMPTY  = 4'd5,
		ST_PORT_LONG   = 4'd6,
		ST_PORT_BAD    = 4'd7,
		ST_LEGACY      = 4'd8,
		ST_BAD_DOMAIN  = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_IPV4   = 2'd1,
		KIND_DOMAIN = 2'd2
	} kind_t;

	// Classification of one input byte, as carried from front to back.
	typedef struct packed {
		logic       last;
		logic       digit;
		logic [3:0] dval;
		logic       dot;
		logic       colon;
		logic       ws;
		logic       lbracket;
		logic       letter;
		logic       hex;
		logic       zero;
		logic       xchar;
		logic       hyphen;
	} cls_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

/* design/hpev_front.sv */
// Front end: accepts input beats and classifies each byte.
module hpev_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              last,
	input  hpev_pkg::fifo_stat_t fstat,
	output logic              push,
	output hpev_pkg::cls_t    cls
);
	import hpev_pkg::*;

	assign in_stall = fstat.full;
	assign push     = in_valid && !fstat.full;

	always_comb begin
		cls          = '0;
		cls.last     = last;
		cls.digit    = (ch inside {[8'h30:8'h39]});
		cls.dval     = ch[3:0];
		cls.dot      = (ch == 8'h2E);
		cls.colon    = (ch == 8'h3A);
		cls.ws       = (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
		cls.lbracket = (ch == 8'h5B);
		cls.letter   = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
		cls.hex      = (ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
		cls.zero     = (ch == 8'h30);
		cls.xchar    = (ch == 8'h78) || (ch == 8'h58);
		cls.hyphen   = (ch == 8'h2D);
	end

endmodule

/* design/hpev_fifo.sv */
// Short queue of classified bytes between front and back.
module hpev_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hpev_pkg::cls_t       push_data,
	input  logic                 pop,
	output hpev_pkg::cls_t       head,
	output hpev_pkg::fifo_stat_t fstat
);
	import hpev_pkg::*;

	cls_t               entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign head        = entry_q[rd_ptr_q];
	assign fstat.empty = (count_q == '0);
	assign fstat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/hpev_back.sv */
// Back end: per-byte parse state, the verdict on the last byte, and the result register.
module hpev_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hpev_pkg::cls_t       head,
	input  hpev_pkg::fifo_stat_t fstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           status,
	output logic [1:0]           kind,
	output logic [15:0]          port,
	output logic [31:0]          ipv4_value,
	output logic [8:0]           host_length
);
	import hpev_pkg::*;

	// Parse state
	logic [8:0]  bc_q, n_bc;
	logic [1:0]  colon_q, n_colon;
	logic        first_q, n_first;
	logic        ws_q, n_ws;
	logic        bracket_q, n_bracket;
	logic        cfirst_q, n_cfirst;
	logic        pbad_q, n_pbad;
	logic [2:0]  pd_q, n_pd;
	logic [16:0] pv_q, n_pv;
	logic [9:0]  oval_q, n_oval;
	logic [1:0]  odig_q, n_odig;
	logic [2:0]  ocnt_q, n_ocnt;
	logic        ook_q, n_ook;
	logic [31:0] shift_q, n_shift;
	logic [1:0]  llen_q, n_llen;
	logic        ldig_q, n_ldig;
	logic        lhex_q, n_lhex;
	logic        lok_q, n_lok;
	logic [6:0]  lab_q, n_lab;
	logic        lhyph_q, n_lhyph;
	logic        dok_q, n_dok;
	logic [8:0]  hl_q, n_hl;

	// Result register
	logic        out_valid_q;
	status_t     status_q;
	kind_t       kind_q;
	logic [15:0] port_q;
	logic [31:0] addr_q;
	logic [8:0]  hlen_q;

	logic        out_free;
	logic        comp_ok;
	logic        hx;
	logic        f_ook;
	logic        is_ipv4;
	logic        is_legacy;
	logic        ended_dot;
	logic [9:0]  dom_len;
	logic        dom_ok;
	status_t     v_status;
	kind_t       v_kind;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !fstat.empty && (!head.last || out_free);

	// Next state for the byte at the head of the queue.
	always_comb begin
		n_bc = bc_q;       n_colon = colon_q;   n_first = first_q;  n_ws = ws_q;
		n_bracket = bracket_q; n_cfirst = cfirst_q; n_pbad = pbad_q;
		n_pd = pd_q;       n_pv = pv_q;
		n_oval = oval_q;   n_odig = odig_q;     n_ocnt = ocnt_q;    n_ook = ook_q;
		n_shift = shift_q;
		n_llen = llen_q;   n_ldig = ldig_q;     n_lhex = lhex_q;    n_lok = lok_q;
		n_lab = lab_q;     n_lhyph = lhyph_q;   n_dok = dok_q;      n_hl = hl_q;
		comp_ok = (llen_q != 2'd0) && (ldig_q || (lhex_q && llen_q > 2'd2));
		hx = 1'b0;

		if (bc_q <= MAX_TEXT) begin
			n_bc = bc_q + 9'd1;
		end
		if (first_q) begin
			n_bracket = head.lbracket;
			n_first   = 1'b0;
		end
		if (head.ws) begin
			n_ws = 1'b1;
		end

		if (head.colon) begin
			if (colon_q == 2'd0 && hl_q == 9'd0) begin
				n_cfirst = 1'b1;
			end
			if (colon_q < 2'd2) begin
				n_colon = colon_q + 2'd1;
			end
		end else if (colon_q == 2'd0) begin
			if (hl_q <= MAX_TEXT) begin
				n_hl = hl_q + 9'd1;
			end
			// Strict dotted quad.
			if (head.digit) begin
				if (odig_q == 2'd1 && oval_q == 10'd0) begin
					n_ook = 1'b0;
				end
				if (odig_q == 2'd3) begin
					n_ook = 1'b0;
				end else begin
					n_oval = 10'(oval_q * 10'd10) + {6'd0, head.dval};
					n_odig = odig_q + 2'd1;
				end
			end else if (head.dot) begin
				if (odig_q == 2'd0 || oval_q > MAX_OCTET) begin
					n_ook = 1'b0;
				end
				n_shift = {shift_q[23:0], oval_q[7:0]};
				if (ocnt_q >= 3'd4) begin
					n_ook = 1'b0;
				end else begin
					n_ocnt = ocnt_q + 3'd1;
				end
				n_oval = '0;
				n_odig = '0;
			end else begin
				n_ook = 1'b0;
			end
			// Legacy numeric components.
			if (head.dot) begin
				if (!comp_ok) begin
					n_lok = 1'b0;
				end
				n_llen = '0;
				n_ldig = 1'b1;
				n_lhex = 1'b1;
			end else begin
				if (!head.digit) begin
					n_ldig = 1'b0;
				end
				case (llen_q)
					2'd0:    hx = head.zero;
					2'd1:    hx = head.xchar;
					default: hx = head.hex;
				endcase
				if (!hx) begin
					n_lhex = 1'b0;
				end
				if (llen_q < 2'd3) begin
					n_llen = llen_q + 2'd1;
				end
			end
			// Domain labels.
			if (head.dot) begin
				if (lab_q == 7'd0 || lab_q > MAX_LABEL || lhyph_q) begin
					n_dok = 1'b0;
				end
				n_lab   = '0;
				n_lhyph = 1'b0;
			end else begin
				if (!(head.letter || head.digit || head.hyphen)) begin
					n_dok = 1'b0;
				end
				if (lab_q == 7'd0 && head.hyphen) begin
					n_dok = 1'b0;
				end
				n_lhyph = head.hyphen;
				if (lab_q <= MAX_LABEL) begin
					n_lab = lab_q + 7'd1;
				end
			end
		end else begin
			if (pd_q <= MAX_PORT_DIGITS) begin
				n_pd = pd_q + 3'd1;
			end
			if (!head.digit) begin
				n_pbad = 1'b1;
			end else if (n_pd <= MAX_PORT_DIGITS) begin
				n_pv = 17'(pv_q * 17'd10) + {13'd0, head.dval};
			end
		end
	end

	// Verdict, taken from the state after the last byte.
	always_comb begin
		f_ook = n_ook && (n_odig != 2'd0) && (n_oval <= MAX_OCTET) && (n_ocnt < 3'd4);
		is_ipv4 = f_ook && (n_ocnt == 3'd3);
		is_legacy = n_lok && (n_hl != 9'd0) &&
			((n_llen == 2'd0) ||
			(n_ldig || (n_lhex && n_llen > 2'd2)));
		ended_dot = (n_lab == 7'd0);
		dom_len = {1'b0, n_hl} - {9'd0, ended_dot};
		dom_ok = n_dok && (n_hl != 9'd0) && (dom_len <= MAX_DOMAIN) &&
			(ended_dot || (n_lab <= MAX_LABEL && !n_lhyph));

		v_kind = KIND_NONE;
		if (n_bc > MAX_TEXT) begin
			v_status = ST_TOO_LONG;
		end else if (n_ws) begin
			v_status = ST_WHITESPACE;
		end else if (n_bracket) begin
			v_status = ST_BRACKETED;
		end else if (n_colon != 2'd1 || n_cfirst) begin
			v_status = ST_BAD_COLON;
		end else if (n_pd == 3'd0) begin
			v_status = ST_PORT_EMPTY;
		end else if (n_pd > MAX_PORT_DIGITS) begin
			v_status = ST_PORT_LONG;
		end else if (n_pbad || n_pv == 17'd0 || n_pv > MAX_PORT) begin
			v_status = ST_PORT_BAD;
		end else if (is_ipv4) begin
			v_status = ST_OK;
			v_kind   = KIND_IPV4;
		end else if (is_legacy) begin
			v_status = ST_LEGACY;
		end else if (dom_ok) begin
			v_status = ST_OK;
			v_kind   = KIND_DOMAIN;
		end else begin
			v_status = ST_BAD_DOMAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= '0;     colon_q <= '0;   first_q <= 1'b1; ws_q <= 1'b0;
			bracket_q <= 1'b0; cfirst_q <= 1'b0; pbad_q <= 1'b0;
			pd_q <= '0;     pv_q <= '0;
			oval_q <= '0;   odig_q <= '0;    ocnt_q <= '0;    ook_q <= 1'b1;
			shift_q <= '0;
			llen_q <= '0;   ldig_q <= 1'b1;  lhex_q <= 1'b1;  lok_q <= 1'b1;
			lab_q <= '0;    lhyph_q <= 1'b0; dok_q <= 1'b1;   hl_q <= '0;
		end else if (pop && head.last) begin
			bc_q <= '0;     colon_q <= '0;   first_q <= 1'b1; ws_q <= 1'b0;
			bracket_q <= 1'b0; cfirst_q <= 1'b0; pbad_q <= 1'b0;
			pd_q <= '0;     pv_q <= '0;
			oval_q <= '0;   odig_q <= '0;    ocnt_q <= '0;    ook_q <= 1'b1;
			shift_q <= '0;
			llen_q <= '0;   ldig_q <= 1'b1;  lhex_q <= 1'b1;  lok_q <= 1'b1;
			lab_q <= '0;    lhyph_q <= 1'b0; dok_q <= 1'b1;   hl_q <= '0;
		end else if (pop) begin
			bc_q <= n_bc;   colon_q <= n_colon; first_q <= n_first; ws_q <= n_ws;
			bracket_q <= n_bracket; cfirst_q <= n_cfirst; pbad_q <= n_pbad;
			pd_q <= n_pd;   pv_q <= n_pv;
			oval_q <= n_oval; odig_q <= n_odig; ocnt_q <= n_ocnt; ook_q <= n_ook;
			shift_q <= n_shift;
			llen_q <= n_llen; ldig_q <= n_ldig; lhex_q <= n_lhex; lok_q <= n_lok;
			lab_q <= n_lab; lhyph_q <= n_lhyph; dok_q <= n_dok;   hl_q <= n_hl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			status_q <= v_status;
			kind_q   <= v_kind;
			port_q   <= (v_status == ST_OK) ? n_pv[15:0] : 16'd0;
			addr_q   <= (v_kind == KIND_IPV4) ? {n_shift[23:0], n_oval[7:0]} : 32'd0;
			hlen_q   <= (v_status == ST_OK || v_status >= ST_PORT_EMPTY) ? n_hl : 9'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign kind        = kind_q;
	assign port        = port_q;
	assign ipv4_value  = addr_q;
	assign host_length = hlen_q;

endmodule

/* design/host_port_endpoint_validator.sv */
// A last byte accepted into the queue has its verdict registered in the result register when it is popped.
// Throughput: one byte per cycle, also across verdicts, while the result is taken.
// The queue holds four beats; the parse state is updated by the back end per byte.
// A held verdict stalls only the queue's last beat; earlier bytes keep flowing.
// Reset is asynchronous and clears queue, parse state and result valid at once.
module host_port_endpoint_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [1:0]  kind,
	output logic [15:0] port,
	output logic [31:0] ipv4_value,
	output logic [8:0]  host_length
);
	import hpev_pkg::*;

	cls_t       cls;
	cls_t       head;
	fifo_stat_t fstat;
	logic       push;
	logic       pop;

	hpev_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.last     (last),
		.fstat    (fstat),
		.push     (push),
		.cls      (cls)
	);

	hpev_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.head      (head),
		.fstat     (fstat)
	);

	hpev_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.fstat       (fstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.kind        (kind),
		.port        (port),
		.ipv4_value  (ipv4_value),
		.host_length (host_length)
	);

endmodule

/* dv/host_port_endpoint_validator_tb.sv */
// Self-checking testbench for the host and port endpoint validator.
module host_port_endpoint_validator_tb;
	import hpev_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		status_t     st;
		kind_t       kd;
		logic [15:0] prt;
		logic [31:0] addr;
		logic [8:0]  hlen;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  status;
	logic [1:0]  kind;
	logic [15:0] port;
	logic [31:0] ipv4_value;
	logic [8:0]  host_length;

	host_port_endpoint_validator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.kind(kind),
		.port(port),
		.ipv4_value(ipv4_value),
		.host_length(host_length)
	);

	verdict_t    pending_verdicts[$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;

	string       case_text[$];
	bit          case_typed[$];
	verdict_t    case_want[$];

	// Parse state of the predictor, cleared after every verdict.
	logic [8:0]  txt_count;
	logic [1:0]  colon_seen;
	bit          at_first, saw_ws, bracketed, colon_lead, port_nondigit;
	logic [2:0]  pdigits;
	logic [16:0] pvalue;
	logic [9:0]  oct_val;
	logic [1:0]  oct_dig;
	logic [2:0]  oct_cnt;
	bit          oct_ok;
	logic [31:0] quad_acc;
	logic [1:0]  comp_len;
	bit          comp_dig, comp_hex, legacy_ok;
	logic [6:0]  lab_len;
	bit          lab_hyphen, dom_ok;
	logic [8:0]  host_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void clear_parse();
		txt_count = '0;
		colon_seen = '0;
		at_first = 1'b1;
		saw_ws = 1'b0;
		bracketed = 1'b0;
		colon_lead = 1'b0;
		port_nondigit = 1'b0;
		pdigits = '0;
		pvalue = '0;
		oct_val = '0;
		oct_dig = '0;
		oct_cnt = '0;
		oct_ok = 1'b1;
		quad_acc = '0;
		comp_len = '0;
		comp_dig = 1'b1;
		comp_hex = 1'b1;
		legacy_ok = 1'b1;
		lab_len = '0;
		lab_hyphen = 1'b0;
		dom_ok = 1'b1;
		host_cnt = '0;
	endfunction

	function automatic void quad_close();
		if (oct_dig == 0 || oct_val > MAX_OCTET)
			oct_ok = 1'b0;
		quad_acc = {quad_acc[23:0], oct_val[7:0]};
		if (oct_cnt >= 3'd4)
			oct_ok = 1'b0;
		else
			oct_cnt = oct_cnt + 3'd1;
		oct_val = '0;
		oct_dig = '0;
	endfunction

	function automatic bit legacy_comp_ok();
		return comp_len != 0 && (comp_dig || (comp_hex && comp_len > 2'd2));
	endfunction

	function automatic void label_close();
		if (lab_len == 0 || lab_len > MAX_LABEL || lab_hyphen)
			dom_ok = 1'b0;
		lab_len = '0;
		lab_hyphen = 1'b0;
	endfunction

	// Advances the parse by one byte; returns 1 with the verdict on a last byte.
	function automatic bit endpoint_step(input logic [7:0] c, input bit lst,
			output verdict_t v);
		bit is_dig, is_let, is_hex, h, dotted;
		is_dig = c >= "0" && c <= "9";
		is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		is_hex = is_dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		v = '0;

		if (txt_count <= MAX_TEXT)
			txt_count = txt_count + 9'd1;
		if (at_first) begin
			bracketed = c == "[";
			at_first = 1'b0;
		end
		if (c == " " || (c >= 8'h09 && c <= 8'h0D))
			saw_ws = 1'b1;

		if (c == ":") begin
			if (colon_seen == 0 && host_cnt == 0)
				colon_lead = 1'b1;
			if (colon_seen < 2'd2)
				colon_seen = colon_seen + 2'd1;
		end else if (colon_seen == 0) begin
			if (host_cnt <= MAX_TEXT)
				host_cnt = host_cnt + 9'd1;

			if (is_dig) begin
				if (oct_dig == 2'd1 && oct_val == 0)
					oct_ok = 1'b0;
				if (oct_dig >= 2'd3) begin
					oct_ok = 1'b0;
				end else begin
					oct_val = oct_val * 10'd10 + {6'd0, c[3:0]};
					oct_dig = oct_dig + 2'd1;
				end
			end else if (c == ".") begin
				quad_close();
			end else begin
				oct_ok = 1'b0;
			end

			if (c == ".") begin
				if (!legacy_comp_ok())
					legacy_ok = 1'b0;
				comp_len = '0;
				comp_dig = 1'b1;
				comp_hex = 1'b1;
			end else begin
				if (!is_dig)
					comp_dig = 1'b0;
				if (comp_len == 0)
					h = c == "0";
				else if (comp_len == 2'd1)
					h = c == "x" || c == "X";
				else
					h = is_hex;
				if (!h)
					comp_hex = 1'b0;
				if (comp_len < 2'd3)
					comp_len = comp_len + 2'd1;
			end

			if (c == ".") begin
				label_close();
			end else begin
				if (!(is_let || is_dig || c == "-"))
					dom_ok = 1'b0;
				if (lab_len == 0 && c == "-")
					dom_ok = 1'b0;
				lab_hyphen = c == "-";
				if (lab_len <= MAX_LABEL)
					lab_len = lab_len + 7'd1;
			end
		end else begin
			if (pdigits <= MAX_PORT_DIGITS)
				pdigits = pdigits + 3'd1;
			if (!is_dig)
				port_nondigit = 1'b1;
			else if (pdigits <= MAX_PORT_DIGITS)
				pvalue = pvalue * 17'd10 + {13'd0, c[3:0]};
		end

		if (!lst)
			return 1'b0;

		v.st = ST_OK;
		v.kd = KIND_NONE;
		if (txt_count > MAX_TEXT)
			v.st = ST_TOO_LONG;
		else if (saw_ws)
			v.st = ST_WHITESPACE;
		else if (bracketed)
			v.st = ST_BRACKETED;
		else if (colon_seen != 2'd1 || colon_lead)
			v.st = ST_BAD_COLON;
		else if (pdigits == 0)
			v.st = ST_PORT_EMPTY;
		else if (pdigits > MAX_PORT_DIGITS)
			v.st = ST_PORT_LONG;
		else if (port_nondigit || pvalue == 0 || pvalue > MAX_PORT)
			v.st = ST_PORT_BAD;
		else begin
			quad_close();
			if (oct_ok && oct_cnt == 3'd4) begin
				v.kd = KIND_IPV4;
				v.addr = quad_acc;
			end else if (legacy_ok && host_cnt != 0 && (comp_len == 0 || legacy_comp_ok())) begin
				v.st = ST_LEGACY;
			end else begin
				// One trailing dot is dropped before the length limit applies.
				dotted = lab_len == 0;
				if (host_cnt == 0)
					dom_ok = 1'b0;
				if (!dotted)
					label_close();
				if (int'(host_cnt) - int'(dotted) > int'(MAX_DOMAIN))
					dom_ok = 1'b0;
				if (dom_ok)
					v.kd = KIND_DOMAIN;
				else
					v.st = ST_BAD_DOMAIN;
			end
			if (v.st == ST_OK)
				v.prt = pvalue[15:0];
		end
		if (v.st == ST_OK || v.st >= ST_PORT_EMPTY)
			v.hlen = host_cnt;
		clear_parse();
		return 1'b1;
	endfunction

	function automatic string repeat_str(string unit, int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, unit};
		return s;
	endfunction

	function automatic byte_q_t to_bytes(string s);
		byte_q_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		return t;
	endfunction

	// Mostly short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_case(string s, bit typed, status_t st, kind_t kd, int prt,
			logic [31:0] addr, int hl);
		verdict_t v;
		v.st = st;
		v.kd = kd;
		v.prt = prt[15:0];
		v.addr = addr;
		v.hlen = hl[8:0];
		case_text.push_back(s);
		case_typed.push_back(typed);
		case_want.push_back(v);
	endtask

	function automatic byte_q_t random_endpoint();
		byte_q_t t;
		string   host, prt, pool, alnum, name_chars;
		int      n, k, shape;
		alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
		name_chars = {alnum, "--._"};
		host = "";
		shape = $urandom_range(0, 99);

		if (shape < 28) begin
			// Dotted quads, with the odd leading zero, big octet or wrong count.
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 4;
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					host = {host, "."};
				case ($urandom_range(0, 9))
					0: host = {host, $sformatf("0%0d", $urandom_range(0, 99))};
					1: host = {host, $sformatf("%0d", $urandom_range(256, 1200))};
					2: host = {host, ($urandom_range(0, 1) != 0) ? "0" : "255"};
					default: host = {host, $sformatf("%0d", $urandom_range(0, 255))};
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				host = {host, "."};
		end else if (shape < 60) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					host = {host, "."};
				k = ($urandom_range(0, 19) == 0) ? $urandom_range(62, 65) : $urandom_range(1, 10);
				for (int j = 0; j < k; j++) begin
					pool = ((j == 0 || j == k - 1) && $urandom_range(0, 7) != 0) ? alnum : name_chars;
					shape = $urandom_range(0, pool.len() - 1);
					host = {host, pool.substr(shape, shape)};
				end
			end
			if ($urandom_range(0, 7) == 0)
				host = {host, "."};
		end else if (shape < 68) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					host = {host, "."};
				case ($urandom_range(0, 5))
					0: host = {host, "0x"};
					1: host = {host, $sformatf("0X%0h", $urandom_range(0, 4095))};
					2: host = {host, $sformatf("0x%0h", $urandom_range(0, 4095))};
					3: host = {host, $sformatf("%0h", $urandom_range(10, 255))};
					default: host = {host, $sformatf("%0d", $urandom_range(0, 99999))};
				endcase
			end
		end else if (shape < 78) begin
			case ($urandom_range(0, 4))
				0: host = "[::1]";
				1: host = "";
				2: host = "a:b";
				3: host = ($urandom_range(0, 1) != 0) ? "a b" : "a\tb";
				default: host = "x.y";
			endcase
		end else if (shape < 96) begin
			// Raw noise, every byte value possible.
			n = $urandom_range(1, 16);
			for (int i = 0; i < n; i++)
				t.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 2) == 0)
				t[$urandom_range(0, n - 1)] = ":";
			return t;
		end else begin
			// Hosts near the domain and text length limits.
			k = $urandom_range(245, 262);
			while (host.len() < k) begin
				if (host.len() != 0)
					host = {host, "."};
				host = {host, repeat_str("h", $urandom_range(1, 63))};
			end
			host = host.substr(0, k - 1);
		end

		case ($urandom_range(0, 15))
			0: prt = "";
			1: prt = "0";
			2: prt = $sformatf("%0d", $urandom_range(65536, 99999));
			3: prt = $sformatf("%06d", $urandom_range(0, 999999));
			4: prt = ($urandom_range(0, 1) != 0) ? "8a" : "x8";
			5: prt = "65535";
			6: prt = "00080";
			7: prt = "1";
			default: prt = $sformatf("%0d", $urandom_range(1, 65535));
		endcase

		t = to_bytes({host, ":", prt});
		if ($urandom_range(0, 7) == 0)
			t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
		return t;
	endfunction

	task automatic send_text(input byte_q_t txt, input bit typed, input verdict_t typed_v);
		verdict_t got;
		int       gap;
		bit       quiet;
		quiet = $urandom_range(0, 5) == 0;
		foreach (txt[i]) begin
			gap = (quiet || $urandom_range(0, 1) != 0) ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			ch <= txt[i];
			last <= i == txt.size() - 1;
			do
				@(posedge clk);
			while (in_stall);
			if (endpoint_step(txt[i], i == txt.size() - 1, got))
				pending_verdicts.push_back(typed ? typed_v : got);
		end
	endtask

	// Result side: alternating stall and pass stretches, some of them long.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (out_stall) begin
				out_stall <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
					: $urandom_range(0, 8);
			end else begin
				out_stall <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected verdict: status %0d kind %0d", status, kind);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (status !== want.st) begin
					$error("status mismatch: expected %0d, actual %0d", want.st, status);
					mismatches++;
				end
				if (kind !== want.kd) begin
					$error("kind mismatch: expected %0d, actual %0d", want.kd, kind);
					mismatches++;
				end
				if (port !== want.prt) begin
					$error("port mismatch: expected %0d, actual %0d", want.prt, port);
					mismatches++;
				end
				if (ipv4_value !== want.addr) begin
					$error("ipv4_value mismatch: expected %08h, actual %08h", want.addr,
						ipv4_value);
					mismatches++;
				end
				if (host_length !== want.hlen) begin
					$error("host_length mismatch: expected %0d, actual %0d", want.hlen,
						host_length);
					mismatches++;
				end
			end
		end
	end

	initial begin
		byte_q_t txt;
		int      random_bytes, texts_sent;
		random_bytes = 0;
		texts_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		ch <= 8'h00;
		last <= 1'b0;
		clear_parse();

		add_case("255.255.255.255:65535", 1, ST_OK, KIND_IPV4, 65535, 32'hFFFF_FFFF, 15);
		add_case("0.0.0.0:1", 1, ST_OK, KIND_IPV4, 1, 32'h0, 7);
		add_case({repeat_str("a", 258), ":80"}, 1, ST_TOO_LONG, KIND_NONE, 0, 0, 0);
		add_case({repeat_str("abc.", 63), "a.:80"}, 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case({repeat_str("x", 63), ".com:22"}, 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case({repeat_str("x", 64), ".com:22"}, 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case("a b:1", 1, ST_WHITESPACE, KIND_NONE, 0, 0, 0);
		add_case("h:8\n", 1, ST_WHITESPACE, KIND_NONE, 0, 0, 0);
		add_case("[::1]:443", 1, ST_BRACKETED, KIND_NONE, 0, 0, 0);
		add_case(":80", 1, ST_BAD_COLON, KIND_NONE, 0, 0, 0);
		add_case("a:1:2", 1, ST_BAD_COLON, KIND_NONE, 0, 0, 0);
		add_case("example", 1, ST_BAD_COLON, KIND_NONE, 0, 0, 0);
		add_case("a:", 1, ST_PORT_EMPTY, KIND_NONE, 0, 0, 1);
		add_case("a:123456", 1, ST_PORT_LONG, KIND_NONE, 0, 0, 1);
		add_case("a:65536", 1, ST_PORT_BAD, KIND_NONE, 0, 0, 1);
		add_case("a:0", 1, ST_PORT_BAD, KIND_NONE, 0, 0, 1);
		add_case("127.1:80", 1, ST_LEGACY, KIND_NONE, 0, 0, 5);
		add_case("0x7f.0.0.1:8080", 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case("-a.b:80", 1, ST_BAD_DOMAIN, KIND_NONE, 0, 0, 4);
		add_case("Example-1.COM.:443", 1, ST_OK, KIND_DOMAIN, 443, 0, 14);
		add_case("01.2.3.4:80", 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case("1.2.3.4.:80", 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case("x", 0, ST_OK, KIND_NONE, 0, 0, 0);
		add_case(":", 0, ST_OK, KIND_NONE, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (case_text[i])
			send_text(to_bytes(case_text[i]), case_typed[i], case_want[i]);

		while (random_bytes < 200 || texts_sent < 16) begin
			txt = random_endpoint();
			send_text(txt, 1'b0, '0);
			random_bytes += txt.size();
			texts_sent++;
		end
		in_valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
